[rtl/core/srsw_pkg.sv]
// Package for the selective-repeat sender window: item types, codes and sizes.
// Shared by srsw_cell and selective_repeat_sender_window. No dependencies.
`default_nettype none

package srsw_pkg;

  localparam int MAX_SLOTS    = 15;
  localparam int SEQ_SPACE    = 30000;
  localparam int HEADER_BYTES = 9;

  localparam int SLOT_W  = 4;
  localparam int SEQ_W   = 15;
  localparam int LEN_W   = 10;
  localparam int SIZE_W  = 11;
  localparam int TIME_W  = 32;
  localparam int TOUT_W  = 16;
  localparam int CFG_W   = 16;

  // Input actions
  localparam logic [2:0] ACT_OFFER = 3'd0;
  localparam logic [2:0] ACT_ACK   = 3'd1;
  localparam logic [2:0] ACT_RETX  = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_FIN   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RETX   = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  // Configuration register indexes
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [2:0]       action;
    logic [LEN_W-1:0] payload_len;
    logic             last_packet;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  seq_out;
    logic [SLOT_W-1:0] slot;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic              busy;
    logic              acked;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ACK   = 3'd2,
    OP_RETX  = 3'd3,
    OP_TICK  = 3'd4,
    OP_SHIFT = 3'd5
  } cell_op_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] deadline;
  } cell_cmd_t;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [SLOT_W-1:0] lowest_idx(input logic [MAX_SLOTS-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[rtl/core/selective_repeat_sender_window.sv]
// Selective-repeat sender window. Offer: one result the cycle after accept.
// Retransmit request / tick: one result per cycle while the output is not stalled, one per
// matching slot, up to 15; the matches go to a mask register, then each result to the output register.
// Ack: marks the matching slot acked; the chain then slides one slot per cycle past acked leading slots.
// Fin: sets the finished flag, no result. One item is in work at a time.
// Reset (rst_n low, synchronous): all slots empty, window 5, timeout 1, time zero.
`default_nettype none

module selective_repeat_sender_window (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire srsw_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output srsw_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [srsw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int N      = srsw_pkg::MAX_SLOTS;
  localparam int SLOT_W = srsw_pkg::SLOT_W;
  localparam int SEQ_W  = srsw_pkg::SEQ_W;
  localparam int TIME_W = srsw_pkg::TIME_W;
  localparam int SIZE_W = srsw_pkg::SIZE_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SLIDE = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]          window_size_r;
  logic [srsw_pkg::TOUT_W-1:0] timeout_r;
  logic [SEQ_W-1:0]           prev_seq_r, prev_seq_nxt;
  logic [SIZE_W-1:0]          prev_size_r, prev_size_nxt;
  logic [TIME_W-1:0]          now_r, now_nxt;
  logic                       ended_r, ended_nxt;
  logic                       finished_r, finished_nxt;
  logic [N-1:0]               mask_r, mask_nxt;
  logic                       out_valid_r, out_valid_nxt;
  srsw_pkg::out_item_t        out_data_r, out_data_nxt;

  srsw_pkg::cell_cmd_t        cmd;
  srsw_pkg::slot_t            cell_st [N];
  logic [N-1:0]               hits;
  logic [N-1:0]               in_win;
  logic [N-1:0]               tail;
  logic [N-1:0]               busy_v;
  logic [N-1:0]               free_v;
  logic [N-1:0]               sel_v;
  logic [SLOT_W-1:0]          w_eff;
  logic [SLOT_W-1:0]          free_idx;
  logic [SLOT_W-1:0]          emit_idx;
  logic [N-1:0]               mask_rest;
  logic [SEQ_W:0]             seq_sum;
  logic [SEQ_W-1:0]           new_seq;
  logic [TIME_W-1:0]          now_inc;
  logic                       accept;
  logic                       out_free;
  logic                       refuse;

  // Window of 0 acts as 1, anything above the slot count as the slot count
  always_comb begin
    if (window_size_r == '0) begin
      w_eff = SLOT_W'(1);
    end else if (window_size_r > SLOT_W'(N)) begin
      w_eff = SLOT_W'(N);
    end else begin
      w_eff = window_size_r;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      in_win[i] = SLOT_W'(i) < w_eff;
      tail[i]   = SLOT_W'(i) == (w_eff - SLOT_W'(1));
      busy_v[i] = cell_st[i].busy;
    end
  end

  assign free_v   = ~busy_v & in_win;
  assign free_idx = srsw_pkg::lowest_idx(free_v);
  assign emit_idx = srsw_pkg::lowest_idx(mask_r);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel_v[i] = SLOT_W'(i) == free_idx;
    end
  end

  // Next sequence number: both terms are below the sequence space, so one subtract
  assign seq_sum = {1'b0, prev_seq_r} + (SEQ_W+1)'(prev_size_r);
  assign new_seq = (seq_sum >= (SEQ_W+1)'(srsw_pkg::SEQ_SPACE)) ?
                   SEQ_W'(seq_sum - (SEQ_W+1)'(srsw_pkg::SEQ_SPACE)) : SEQ_W'(seq_sum);
  assign now_inc = now_r + TIME_W'(1);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign refuse   = finished_r || ended_r || (free_v == '0);

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mask_rest = mask_r & (mask_r - N'(1));

  // Slot chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    srsw_pkg::slot_t nb;
    if (g < N - 1) begin : g_mid
      assign nb = cell_st[g+1];
    end else begin : g_top
      assign nb = '0;
    end
    srsw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .sel       (sel_v[g]),
      .in_win    (in_win[g]),
      .tail      (tail[g]),
      .next_slot (nb),
      .slot_q    (cell_st[g]),
      .hit       (hits[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    prev_seq_nxt  = prev_seq_r;
    prev_size_nxt = prev_size_r;
    now_nxt       = now_r;
    ended_nxt     = ended_r;
    finished_nxt  = finished_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd.op        = srsw_pkg::OP_NONE;
    cmd.seq       = in_data.ack_seq;
    cmd.now       = now_r;
    cmd.deadline  = now_r + TIME_W'(timeout_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == srsw_pkg::ACT_OFFER) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.last_of_run = 1'b1;
            if (refuse) begin
              out_data_nxt.kind    = srsw_pkg::KIND_REFUSE;
              out_data_nxt.seq_out = '0;
              out_data_nxt.slot    = '0;
            end else begin
              cmd.op               = srsw_pkg::OP_LOAD;
              cmd.seq              = new_seq;
              prev_seq_nxt         = new_seq;
              prev_size_nxt        = {1'b0, in_data.payload_len} +
                                     SIZE_W'(srsw_pkg::HEADER_BYTES);
              if (in_data.last_packet) ended_nxt = 1'b1;
              out_data_nxt.kind    = srsw_pkg::KIND_NEW;
              out_data_nxt.seq_out = new_seq;
              out_data_nxt.slot    = free_idx;
            end
          end else if (!finished_r) begin
            case (in_data.action)
              srsw_pkg::ACT_ACK: begin
                cmd.op    = srsw_pkg::OP_ACK;
                state_nxt = S_SLIDE;
              end
              srsw_pkg::ACT_RETX: begin
                cmd.op   = srsw_pkg::OP_RETX;
                mask_nxt = hits;
                if (hits != '0) state_nxt = S_EMIT;
              end
              srsw_pkg::ACT_TICK: begin
                cmd.op       = srsw_pkg::OP_TICK;
                cmd.now      = now_inc;
                cmd.deadline = now_inc + TIME_W'(timeout_r);
                now_nxt      = now_inc;
                mask_nxt     = hits;
                if (hits != '0) state_nxt = S_EMIT;
              end
              srsw_pkg::ACT_FIN: begin
                finished_nxt = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_SLIDE: begin
        // drop the oldest slot while it is acked
        if (cell_st[0].busy && cell_st[0].acked) begin
          cmd.op = srsw_pkg::OP_SHIFT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = srsw_pkg::KIND_RETX;
          out_data_nxt.seq_out     = cell_st[emit_idx].seq;
          out_data_nxt.slot        = emit_idx;
          out_data_nxt.last_of_run = (mask_rest == '0);
          mask_nxt                 = mask_rest;
          if (mask_rest == '0) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      window_size_r <= SLOT_W'(5);
      timeout_r     <= srsw_pkg::TOUT_W'(1);
      prev_seq_r    <= '0;
      prev_size_r   <= '0;
      now_r         <= '0;
      ended_r       <= 1'b0;
      finished_r    <= 1'b0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_seq_r  <= prev_seq_nxt;
      prev_size_r <= prev_size_nxt;
      now_r       <= now_nxt;
      ended_r     <= ended_nxt;
      finished_r  <= finished_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          srsw_pkg::REG_WINDOW:  window_size_r <= cfg_data[SLOT_W-1:0];
          srsw_pkg::REG_TIMEOUT: timeout_r     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/srsw_cell.sv]
// One window slot of the sender window chain: sequence, deadline, acked, busy.
// Takes its upper neighbour's slot on a slide inside the window (the tail slot empties). Depends on srsw_pkg.
`default_nettype none

module srsw_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire srsw_pkg::cell_cmd_t cmd,
  input  wire logic              sel,
  input  wire logic              in_win,
  input  wire logic              tail,
  input  wire srsw_pkg::slot_t   next_slot,
  output srsw_pkg::slot_t        slot_q,
  output logic                   hit
);

  srsw_pkg::slot_t st_r;
  srsw_pkg::slot_t st_nxt;
  logic [srsw_pkg::TIME_W-1:0] age;

  assign age    = cmd.now - st_r.deadline;
  assign slot_q = st_r;

  always_comb begin
    case (cmd.op)
      srsw_pkg::OP_ACK, srsw_pkg::OP_RETX: begin
        hit = in_win && st_r.busy && (st_r.seq == cmd.seq);
      end
      srsw_pkg::OP_TICK: begin
        // expired when the deadline lies in the past half of the time circle
        hit = in_win && st_r.busy && !st_r.acked && !age[srsw_pkg::TIME_W-1];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (cmd.op)
      srsw_pkg::OP_LOAD: begin
        if (sel) begin
          st_nxt.busy     = 1'b1;
          st_nxt.acked    = 1'b0;
          st_nxt.seq      = cmd.seq;
          st_nxt.deadline = cmd.deadline;
        end
      end
      srsw_pkg::OP_ACK: begin
        if (hit) st_nxt.acked = 1'b1;
      end
      srsw_pkg::OP_RETX, srsw_pkg::OP_TICK: begin
        if (hit) st_nxt.deadline = cmd.deadline;
      end
      srsw_pkg::OP_SHIFT: begin
        // slots beyond the window hold still
        if (in_win) st_nxt = tail ? '0 : next_slot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

`default_nettype wire
